[rtl/joukowski_airfoil_point_defines.svh]
// Assertion macros for the Joukowski airfoil point generator
`ifndef JOUKOWSKI_AIRFOIL_POINT_DEFINES_SVH
`define JOUKOWSKI_AIRFOIL_POINT_DEFINES_SVH
`ifndef SYNTH
`define JAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define JAP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define JAP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/jap_pkg.sv]
// Shared types and constants of the Joukowski airfoil point generator
`default_nettype none
package jap_pkg;
  localparam int ANGLE_W    = 16;
  localparam int COORD_W    = 16;
  localparam int A_W        = 15;
  localparam int SCALE_W    = 11;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ANG_SHIFT  = 17;
  localparam int TH_W       = 35;
  localparam int XY_W       = 32;
  localparam int R_W        = 17;
  localparam int SQ_IN_W    = 34;
  localparam int Z_W        = 19;
  localparam int A2_W       = 30;
  localparam int SQ_W       = 37;
  localparam int NUM_W      = 48;
  localparam int REM_W      = 37;
  localparam int ATAN_N     = 24;
  localparam int Q_SHIFT    = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A     = 2'd0,
    CFG_X0    = 2'd1,
    CFG_Y0    = 2'd2,
    CFG_SCALE = 2'd3
  } cfg_idx_t;

  typedef logic signed [TH_W-1:0] th_t;

  localparam th_t Q30_HALF_PI = 35'sd1686629713;
  localparam th_t Q30_PI      = 35'sd3373259426;
  localparam th_t Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam th_t ATAN_Q30 [ATAN_N] = '{
    35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158, 35'sd67021686,
    35'sd33543515,  35'sd16775850,  35'sd8388437,   35'sd4194282,   35'sd2097149,
    35'sd1048575,   35'sd524287,    35'sd262143,    35'sd131071,    35'sd65535,
    35'sd32767,     35'sd16383,     35'sd8191,      35'sd4095,      35'sd2047,
    35'sd1023,      35'sd511,       35'sd255,       35'sd127
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    th_t                    th;
    logic                   neg;
  } cordic_t;

  typedef struct packed {
    logic signed [Z_W-1:0] zx;
    logic signed [Z_W-1:0] zy;
    logic                  dz;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [SQ_W-1:0]  den;
    side_t            side;
  } div_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] circle_x;
    logic signed [PIX_W-1:0] circle_y;
    logic signed [PIX_W-1:0] airfoil_x;
    logic signed [PIX_W-1:0] airfoil_y;
    logic                    div_zero;
  } pix_t;

  typedef struct packed {
    logic             busy;
    logic [R_W-1:0]   radius;
  } sqrt_stat_t;
endpackage
`default_nettype wire

[rtl/jap_if.sv]
// Channel interfaces: angle requests, point results and register writes
`default_nettype none
interface jap_in_if;
  import jap_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;
  modport source(output valid, angle, input ready);
  modport sink(input valid, angle, output ready);
endinterface

interface jap_out_if;
  import jap_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] circle_x;
  logic signed [PIX_W-1:0] circle_y;
  logic signed [PIX_W-1:0] airfoil_x;
  logic signed [PIX_W-1:0] airfoil_y;
  logic                    div_zero;
  modport source(output valid, circle_x, circle_y, airfoil_x, airfoil_y, div_zero,
                 input ready);
  modport sink(input valid, circle_x, circle_y, airfoil_x, airfoil_y, div_zero,
               output ready);
endinterface

interface jap_cfg_if;
  import jap_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/jap_cordic_cell.sv]
// One rotation-mode CORDIC cell with its output register
`default_nettype none
module jap_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  jap_pkg::cordic_t in_d,
  output logic             out_valid,
  output jap_pkg::cordic_t out_d
);
  import jap_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  cordic_t                d_nxt;
  cordic_t                d_r;
  logic                   valid_r;

  always_comb begin
    dx    = $signed(in_d.y) >>> STAGE;
    dy    = $signed(in_d.x) >>> STAGE;
    d_nxt = in_d;
    if (!in_d.th[TH_W-1]) begin
      d_nxt.x  = in_d.x - dx;
      d_nxt.y  = in_d.y + dy;
      d_nxt.th = in_d.th - ATAN_Q30[STAGE];
    end else begin
      d_nxt.x  = in_d.x + dx;
      d_nxt.y  = in_d.y - dy;
      d_nxt.th = in_d.th + ATAN_Q30[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
endmodule
`default_nettype wire

[rtl/jap_div_cell.sv]
// One restoring-division step for both quotient lanes, with its register
`default_nettype none
module jap_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  jap_pkg::div_t in_d,
  output logic          out_valid,
  output jap_pkg::div_t out_d
);
  import jap_pkg::*;

  logic [REM_W:0] tx;
  logic [REM_W:0] ty;
  logic [REM_W:0] dsub_x;
  logic [REM_W:0] dsub_y;
  logic           gex;
  logic           gey;
  div_t           d_nxt;
  div_t           d_r;
  logic           valid_r;

  always_comb begin
    tx     = {in_d.rem_x, in_d.num_x[NUM_W-1]};
    ty     = {in_d.rem_y, in_d.num_y[NUM_W-1]};
    gex    = tx >= {1'b0, in_d.den};
    gey    = ty >= {1'b0, in_d.den};
    dsub_x = tx - {1'b0, in_d.den};
    dsub_y = ty - {1'b0, in_d.den};
    d_nxt       = in_d;
    d_nxt.rem_x = gex ? dsub_x[REM_W-1:0] : tx[REM_W-1:0];
    d_nxt.rem_y = gey ? dsub_y[REM_W-1:0] : ty[REM_W-1:0];
    // shift the quotient bit in where the dividend bit leaves
    d_nxt.num_x = {in_d.num_x[NUM_W-2:0], gex};
    d_nxt.num_y = {in_d.num_y[NUM_W-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
endmodule
`default_nettype wire

[rtl/jap_isqrt.sv]
// Circle radius: integer square root of (|x0|+a)^2 + y0^2, one result bit per cycle
`default_nettype none
module jap_isqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [jap_pkg::A_W-1:0]             a,
  input  logic signed [jap_pkg::COORD_W-1:0]  x0,
  input  logic signed [jap_pkg::COORD_W-1:0]  y0,
  output jap_pkg::sqrt_stat_t                 stat
);
  import jap_pkg::*;

  typedef enum logic [1:0] {SQ_IDLE, SQ_MUL, SQ_ADD, SQ_ITER} sq_state_t;

  localparam logic [4:0] K_TOP = 5'(R_W - 1);

  sq_state_t            state_r;
  logic [SQ_IN_W-1:0]   sx2_r;
  logic [SQ_IN_W-1:0]   y2_r;
  logic [SQ_IN_W-1:0]   v_r;
  logic [SQ_IN_W-1:0]   res_r;
  logic [4:0]           k_r;
  logic [R_W-1:0]       radius_r;

  logic [COORD_W-1:0]        abs_x0;
  logic [R_W-1:0]            sx;
  logic signed [2*COORD_W-1:0] y2;
  logic [SQ_IN_W-1:0]        bitv;
  logic [SQ_IN_W-1:0]        trial;
  logic                      take;
  logic [SQ_IN_W-1:0]        res_nxt;

  always_comb begin
    abs_x0  = x0[COORD_W-1] ? COORD_W'(-x0) : COORD_W'(x0);
    sx      = R_W'(abs_x0) + R_W'(a);
    y2      = y0 * y0;
    bitv    = SQ_IN_W'(1) << {k_r, 1'b0};
    trial   = res_r + bitv;
    take    = v_r >= trial;
    res_nxt = take ? ((res_r >> 1) + bitv) : (res_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_MUL;
    end else if (start) begin
      state_r <= SQ_MUL;
    end else begin
      unique case (state_r)
        SQ_IDLE: begin
        end
        SQ_MUL: begin
          sx2_r   <= SQ_IN_W'(sx) * SQ_IN_W'(sx);
          y2_r    <= SQ_IN_W'(unsigned'(y2));
          state_r <= SQ_ADD;
        end
        SQ_ADD: begin
          v_r     <= sx2_r + y2_r;
          res_r   <= '0;
          k_r     <= K_TOP;
          state_r <= SQ_ITER;
        end
        SQ_ITER: begin
          if (take) begin
            v_r <= v_r - trial;
          end
          res_r <= res_nxt;
          if (k_r == 5'd0) begin
            radius_r <= res_nxt[R_W-1:0];
            state_r  <= SQ_IDLE;
          end else begin
            k_r <= k_r - 5'd1;
          end
        end
        default: state_r <= SQ_IDLE;
      endcase
    end
  end

  assign stat.busy   = (state_r != SQ_IDLE);
  assign stat.radius = radius_r;
endmodule
`default_nettype wire

[rtl/joukowski_airfoil_point.sv]
// Top level: Joukowski airfoil point generator, CORDIC and divider cell chains
// Throughput: one angle per cycle while the skid slot is free and no radius update runs;
//   every CORDIC and divider cell takes a new item each cycle while the skid slot is free.
// Reset sets the configuration registers to their defaults and recomputes the radius; the
//   radius is also recomputed after each write of a or the centre, and no angle is accepted
//   while it is recomputed.
`default_nettype none
`include "joukowski_airfoil_point_defines.svh"
module joukowski_airfoil_point #(
  parameter int FRAC_BITS     = 12,
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  jap_in_if.sink    in_ch,
  jap_out_if.source out_ch,
  jap_cfg_if.sink   cfg_ch
);
  import jap_pkg::*;

  localparam int NC   = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
  localparam int PR_W = R_W + 1 + XY_W;
  localparam int W_W  = NUM_W + 1;
  localparam int P_W  = W_W + SCALE_W + 1;
  localparam logic signed [PR_W-1:0] HALF = PR_W'(1) << (Q_SHIFT - 1);
  localparam logic signed [P_W-1:0]  RND  = (P_W'(1) << FRAC_BITS) - P_W'(1);
  localparam logic signed [P_W-1:0]  PMAX = P_W'(32'sd32767);
  localparam logic signed [P_W-1:0]  PMIN = P_W'(-32'sd32768);

  function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] t;
    t = (p + (p[P_W-1] ? RND : P_W'(0))) >>> FRAC_BITS;
    if (t > PMAX) begin
      t = PMAX;
    end else if (t < PMIN) begin
      t = PMIN;
    end
    return PIX_W'(t);
  endfunction

  // configuration registers
  logic [A_W-1:0]            a_r;
  logic signed [COORD_W-1:0] x0_r;
  logic signed [COORD_W-1:0] y0_r;
  logic [SCALE_W-1:0]        scale_r;
  logic [A2_W-1:0]           a2_r;
  logic                      cfg_wr;
  logic                      recalc;
  sqrt_stat_t                sq;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid & cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r     <= A_W'(4096);
      x0_r    <= -COORD_W'(819);
      y0_r    <= -COORD_W'(819);
      scale_r <= SCALE_W'(100);
      a2_r    <= A2_W'(4096 * 4096);
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_A: begin
          a_r  <= cfg_ch.data[A_W-1:0];
          a2_r <= A2_W'(cfg_ch.data[A_W-1:0]) * A2_W'(cfg_ch.data[A_W-1:0]);
        end
        CFG_X0:    x0_r    <= cfg_ch.data;
        CFG_Y0:    y0_r    <= cfg_ch.data;
        CFG_SCALE: scale_r <= cfg_ch.data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign recalc = cfg_wr && (cfg_idx_t'(cfg_ch.index) != CFG_SCALE);

  jap_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (recalc),
    .a     (a_r),
    .x0    (x0_r),
    .y0    (y0_r),
    .stat  (sq)
  );

  // pipeline control: every stage advances while the skid slot is free
  logic adv;
  logic acc;
  logic skid_valid_r;
  logic out_valid_r;
  pix_t out_r;
  pix_t skid_r;
  logic pop;

  assign adv         = !skid_valid_r;
  assign in_ch.ready = adv && !sq.busy;
  assign acc         = in_ch.valid && in_ch.ready;

  // angle reduction stages
  logic               v0_r, v1_r, v2_r, v3_r;
  logic [ANGLE_W-1:0] ang0_r;
  th_t                th0;
  th_t                th1_r;
  th_t                th2_r;
  cordic_t            p3_r;
  cordic_t            p3_nxt;

  always_comb begin
    th0    = th_t'({ang0_r, ANG_SHIFT'(0)});
    p3_nxt = '{x: CORDIC_GAIN, y: '0, th: th2_r, neg: 1'b0};
    if (th2_r > Q30_HALF_PI) begin
      p3_nxt.th  = th2_r - Q30_PI;
      p3_nxt.neg = 1'b1;
    end else if (th2_r < -Q30_HALF_PI) begin
      p3_nxt.th  = th2_r + Q30_PI;
      p3_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v0_r <= acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang0_r <= in_ch.angle;
      th1_r  <= (th0 >= Q30_TWO_PI) ? th0 - Q30_TWO_PI : th0;
      th2_r  <= (th1_r > Q30_PI) ? th1_r - Q30_TWO_PI : th1_r;
      p3_r   <= p3_nxt;
    end
  end

  // CORDIC chain
  cordic_t cd [NC+1];
  logic    cv [NC+1];

  assign cd[0] = p3_r;
  assign cv[0] = v3_r;

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    jap_cordic_cell #(.STAGE(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (cv[g]),
      .in_d      (cd[g]),
      .out_valid (cv[g+1]),
      .out_d     (cd[g+1])
    );
  end

  // circle point and divider set-up
  logic                    vm1_r, vm2_r, vm3_r, vm4_r, vm5_r;
  logic signed [XY_W-1:0]  co_r, si_r;
  logic signed [PR_W-1:0]  px_r, py_r;
  logic signed [PR_W-1:0]  rx, ry;
  logic signed [Z_W-1:0]   zx_r, zy_r;
  logic [Z_W-1:0]          abs_zx, abs_zy;
  logic signed [2*Z_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]         sqx_r, sqy_r;
  logic [NUM_W-1:0]        numx_r, numy_r;
  side_t                   side4_r;
  div_t                    dv [NUM_W+1];
  logic                    dvv [NUM_W+1];
  div_t                    d5_r;

  always_comb begin
    rx     = (px_r + HALF) >>> Q_SHIFT;
    ry     = (py_r + HALF) >>> Q_SHIFT;
    abs_zx = zx_r[Z_W-1] ? Z_W'(-zx_r) : Z_W'(zx_r);
    abs_zy = zy_r[Z_W-1] ? Z_W'(-zy_r) : Z_W'(zy_r);
    sqx    = zx_r * zx_r;
    sqy    = zy_r * zy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vm3_r <= 1'b0;
      vm4_r <= 1'b0;
      vm5_r <= 1'b0;
    end else if (adv) begin
      vm1_r <= cv[NC];
      vm2_r <= vm1_r;
      vm3_r <= vm2_r;
      vm4_r <= vm3_r;
      vm5_r <= vm4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      co_r       <= cd[NC].neg ? -cd[NC].x : cd[NC].x;
      si_r       <= cd[NC].neg ? -cd[NC].y : cd[NC].y;
      px_r       <= $signed({1'b0, sq.radius}) * co_r;
      py_r       <= $signed({1'b0, sq.radius}) * si_r;
      zx_r       <= Z_W'(rx + PR_W'(x0_r));
      zy_r       <= Z_W'(ry + PR_W'(y0_r));
      sqx_r      <= SQ_W'(unsigned'(sqx));
      sqy_r      <= SQ_W'(unsigned'(sqy));
      numx_r     <= NUM_W'(a2_r) * NUM_W'(abs_zx);
      numy_r     <= NUM_W'(a2_r) * NUM_W'(abs_zy);
      side4_r.zx <= zx_r;
      side4_r.zy <= zy_r;
      side4_r.dz <= (zx_r == '0) && (zy_r == '0);
      d5_r.rem_x <= '0;
      d5_r.rem_y <= '0;
      d5_r.num_x <= numx_r;
      d5_r.num_y <= numy_r;
      d5_r.den   <= sqx_r + sqy_r;
      d5_r.side  <= side4_r;
    end
  end

  // divider chain
  assign dv[0]  = d5_r;
  assign dvv[0] = vm5_r;

  for (genvar g = 0; g < NUM_W; g++) begin : g_div
    jap_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dvv[g]),
      .in_d      (dv[g]),
      .out_valid (dvv[g+1]),
      .out_d     (dv[g+1])
    );
  end

  // airfoil point, scaling and saturation
  logic                    vf1_r, vf2_r, vf3_r;
  logic signed [W_W-1:0]   qx, qy;
  logic signed [W_W-1:0]   cx_r, cy_r, wx_r, wy_r;
  logic                    dz1_r, dz2_r;
  logic signed [P_W-1:0]   pcx_r, pcy_r, pwx_r, pwy_r;
  pix_t                    f3_r;
  side_t                   sd;

  always_comb begin
    sd = dv[NUM_W].side;
    qx = $signed({1'b0, dv[NUM_W].num_x});
    qy = $signed({1'b0, dv[NUM_W].num_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r <= 1'b0;
      vf2_r <= 1'b0;
      vf3_r <= 1'b0;
    end else if (adv) begin
      vf1_r <= dvv[NUM_W];
      vf2_r <= vf1_r;
      vf3_r <= vf2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r  <= W_W'(sd.zx);
      cy_r  <= W_W'(sd.zy);
      dz1_r <= sd.dz;
      if (sd.dz) begin
        wx_r <= '0;
        wy_r <= '0;
      end else begin
        wx_r <= W_W'(sd.zx) + (sd.zx[Z_W-1] ? -qx : qx);
        wy_r <= W_W'(sd.zy) - (sd.zy[Z_W-1] ? -qy : qy);
      end
      pcx_r          <= cx_r * $signed({1'b0, scale_r});
      pcy_r          <= cy_r * $signed({1'b0, scale_r});
      pwx_r          <= wx_r * $signed({1'b0, scale_r});
      pwy_r          <= wy_r * $signed({1'b0, scale_r});
      dz2_r          <= dz1_r;
      f3_r.circle_x  <= to_pix(pcx_r);
      f3_r.circle_y  <= to_pix(pcy_r);
      f3_r.airfoil_x <= to_pix(pwx_r);
      f3_r.airfoil_y <= to_pix(pwy_r);
      f3_r.div_zero  <= dz2_r;
    end
  end

  // output register and skid slot
  assign pop = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (vf3_r) begin
      if (!out_valid_r || pop) begin
        out_r       <= f3_r;
        out_valid_r <= 1'b1;
      end else begin
        // hold the new result aside while the output waits
        skid_r       <= f3_r;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.circle_x  = out_r.circle_x;
  assign out_ch.circle_y  = out_r.circle_y;
  assign out_ch.airfoil_x = out_r.airfoil_x;
  assign out_ch.airfoil_y = out_r.airfoil_y;
  assign out_ch.div_zero  = out_r.div_zero;

  `JAP_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid full without output")
  `JAP_ASSERT_IMP(a_no_accept_busy, clk, rst_n, sq.busy, !in_ch.ready, "angle accepted during radius update")
  `JAP_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid_r && out_r.div_zero, (out_r.airfoil_x == '0) && (out_r.airfoil_y == '0), "airfoil not zero on zero circle point")
  `JAP_ASSERT_NXT(a_accept_enters, clk, rst_n, acc, v0_r, "accepted angle lost at input stage")
endmodule
`default_nettype wire
